FILE: hw/rtl/uig_pkg.sv
// Shared types, constants and helpers for the UDP/IPv4 header generator.
// No dependencies; the front, queue, back, top level and testbench import this package.
package uig_pkg;

    // Payload limit and fixed header contents.
    localparam logic [15:0] MAX_PAYLOAD_BYTES = 16'd65507;
    localparam logic [7:0]  HDR_VER_IHL       = 8'h45;
    localparam logic [7:0]  HDR_TTL           = 8'd250;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;
    localparam logic [15:0] IP_HDR_BYTES      = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES     = 16'd8;
    localparam logic [2:0]  HDR_WORDS         = 3'd7;
    localparam logic [2:0]  HDR_LAST_IDX      = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SOURCE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_SOURCE_PORT    = 3'd1;
    localparam logic [2:0] CFG_DEST_ADDRESS   = 3'd2;
    localparam logic [2:0] CFG_DEST_PORT      = 3'd3;
    localparam logic [2:0] CFG_USE_ANNOTATION = 3'd4;
    localparam logic [2:0] CFG_UDP_SUM_ENABLE = 3'd5;

    // Descriptor queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One finished packet as handed from the front to the back.
    typedef struct packed {
        logic [31:0] payload_sum;
        logic [15:0] payload_length;
        logic [31:0] dest;
        logic [15:0] packet_id;
    } t_desc;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic        use_annotation;
        logic        udp_sum_enable;
    } t_cfg;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_SUM,
        B_FOLD,
        B_EMIT
    } t_back_state;

    // Ones-complement fold of a 20-bit partial sum down to 16 bits.
    function automatic logic [15:0] fold20(input logic [19:0] x);
        logic [16:0] t;
        logic [16:0] f;
        t = {1'b0, x[15:0]} + {13'b0, x[19:16]};
        f = {1'b0, t[15:0]} + {16'b0, t[16]};
        return f[15:0];
    endfunction

endpackage

FILE: hw/rtl/uig_in_if.sv
// Payload input channel of the UDP/IPv4 header generator.
// Depends on nothing; carries valid, ready and one payload item.
interface uig_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_word;
    logic [2:0]  valid_bytes;
    logic        end_of_payload;
    logic [31:0] dest_annotation;

    modport source (output valid, payload_word, valid_bytes, end_of_payload,
                    dest_annotation, input ready);
    modport sink   (input valid, payload_word, valid_bytes, end_of_payload,
                    dest_annotation, output ready);
endinterface

FILE: hw/rtl/uig_out_if.sv
// Header output channel of the UDP/IPv4 header generator.
// Depends on nothing; carries valid, ready and one header item.
interface uig_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic        header_last;

    modport source (output valid, header_word, header_last, input ready);
    modport sink   (input valid, header_word, header_last, output ready);
endinterface

FILE: hw/rtl/uig_front.sv
// Front end: accepts payload items, keeps the running sum and byte count,
// and pushes one descriptor per packet. Uses uig_pkg and uig_in_if.
module uig_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    uig_in_if.sink                 i_pkt,
    input  logic                   i_use_annotation,
    input  logic [31:0]            i_dest_address,
    input  uig_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output uig_pkg::t_desc         o_push_desc
);
    import uig_pkg::*;

    logic [31:0] r_sum;
    logic [15:0] r_len;
    logic [15:0] r_id;

    logic [2:0]  nb_clamp;
    logic [15:0] room;
    logic [2:0]  nb;
    logic [31:0] word_masked;
    logic [16:0] word_halves;
    logic [32:0] acc;
    logic [31:0] n_sum;
    logic [15:0] n_len;
    logic        accept;

    // Accept whenever the descriptor queue has space.
    assign i_pkt.ready = !i_q_status.full;
    assign accept      = i_pkt.valid && i_pkt.ready;

    // Byte count of this item, limited to four and to the space left.
    always_comb begin
        nb_clamp = (i_pkt.valid_bytes > 3'd4) ? 3'd4 : i_pkt.valid_bytes;
        room     = (r_len < MAX_PAYLOAD_BYTES) ? (MAX_PAYLOAD_BYTES - r_len) : 16'd0;
        nb       = ({13'b0, nb_clamp} > room) ? room[2:0] : nb_clamp;
    end

    // Zero the unused low bytes, then add both halves with end-around carry.
    always_comb begin
        unique case (nb)
            3'd0:    word_masked = 32'h0000_0000;
            3'd1:    word_masked = i_pkt.payload_word & 32'hFF00_0000;
            3'd2:    word_masked = i_pkt.payload_word & 32'hFFFF_0000;
            3'd3:    word_masked = i_pkt.payload_word & 32'hFFFF_FF00;
            default: word_masked = i_pkt.payload_word;
        endcase
        word_halves = {1'b0, word_masked[31:16]} + {1'b0, word_masked[15:0]};
        acc         = {1'b0, r_sum} + {16'b0, word_halves};
        n_sum       = acc[31:0] + {31'b0, acc[32]};
        n_len       = r_len + {13'b0, nb};
    end

    // Running packet state; cleared after the last item of a packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_len <= '0;
            r_id  <= '0;
        end else if (accept) begin
            if (i_pkt.end_of_payload) begin
                r_sum <= '0;
                r_len <= '0;
                r_id  <= r_id + 16'd1;
            end else begin
                r_sum <= n_sum;
                r_len <= n_len;
            end
        end
    end

    // Descriptor of the finished packet.
    assign o_push                     = accept && i_pkt.end_of_payload;
    assign o_push_desc.payload_sum    = n_sum;
    assign o_push_desc.payload_length = n_len;
    assign o_push_desc.dest           = i_use_annotation ? i_pkt.dest_annotation
                                                         : i_dest_address;
    assign o_push_desc.packet_id      = r_id;

endmodule

FILE: hw/rtl/uig_queue.sv
// Short descriptor queue between the front and back ends.
// Uses uig_pkg for the descriptor type and depth.
module uig_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  uig_pkg::t_desc         i_push_desc,
    input  logic                   i_pop,
    output uig_pkg::t_desc         o_head,
    output uig_pkg::t_queue_status o_status
);
    import uig_pkg::*;

    t_desc               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/uig_back.sv
// Back end: takes one descriptor, forms both checksums, and sends the
// seven header items through a registered output. Uses uig_pkg, uig_out_if.
module uig_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  uig_pkg::t_cfg          i_cfg,
    input  uig_pkg::t_desc         i_head,
    input  uig_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    uig_out_if.source              o_hdr
);
    import uig_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_desc       r_desc;
    logic [19:0] r_ip_acc;
    logic [19:0] r_udp_acc;
    logic [15:0] r_ip_sum;
    logic [15:0] r_udp_sum;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_last;

    logic        out_load;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [19:0] ip_acc;
    logic [19:0] udp_acc;
    logic [15:0] ip_fold;
    logic [15:0] udp_fold;
    logic [15:0] udp_csum;
    logic [31:0] word_sel;

    // Lengths fit in 16 bits since the payload is capped.
    assign ip_len  = IP_HDR_BYTES + UDP_HDR_BYTES + r_desc.payload_length;
    assign udp_len = UDP_HDR_BYTES + r_desc.payload_length;

    // First pass: plain sums of the 16-bit terms of both checksums.
    always_comb begin
        ip_acc = {4'b0, HDR_VER_IHL, 8'h00} + {4'b0, ip_len} + {4'b0, r_desc.packet_id}
               + {4'b0, HDR_TTL, PROTO_UDP}
               + {4'b0, i_cfg.source_address[31:16]} + {4'b0, i_cfg.source_address[15:0]}
               + {4'b0, r_desc.dest[31:16]} + {4'b0, r_desc.dest[15:0]};
        udp_acc = {4'b0, r_desc.payload_sum[31:16]} + {4'b0, r_desc.payload_sum[15:0]}
                + {4'b0, i_cfg.source_port} + {4'b0, i_cfg.dest_port}
                + {3'b0, udp_len, 1'b0}
                + {4'b0, i_cfg.source_address[31:16]} + {4'b0, i_cfg.source_address[15:0]}
                + {4'b0, r_desc.dest[31:16]} + {4'b0, r_desc.dest[15:0]}
                + {12'b0, PROTO_UDP};
    end

    // Second pass: fold, complement, and map a zero UDP checksum to all ones; the UDP checksum is zero when disabled.
    always_comb begin
        ip_fold  = fold20(r_ip_acc);
        udp_fold = fold20(r_udp_acc);
        udp_csum = ~udp_fold;
        if (!i_cfg.udp_sum_enable) begin
            udp_csum = 16'h0000;
        end else if (udp_csum == 16'h0000) begin
            udp_csum = 16'hFFFF;
        end
    end

    // Header item selected by the word counter.
    always_comb begin
        unique case (r_idx)
            3'd0:    word_sel = {HDR_VER_IHL, 8'h00, ip_len};
            3'd1:    word_sel = {r_desc.packet_id, 16'h0000};
            3'd2:    word_sel = {HDR_TTL, PROTO_UDP, r_ip_sum};
            3'd3:    word_sel = i_cfg.source_address;
            3'd4:    word_sel = r_desc.dest;
            3'd5:    word_sel = {i_cfg.source_port, i_cfg.dest_port};
            3'd6:    word_sel = {udp_len, r_udp_sum};
            default: word_sel = 32'h0000_0000;
        endcase
    end

    // Next state, queue pop and output load.
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = B_SUM;
                end
            end
            B_SUM: begin
                n_state = B_FOLD;
            end
            B_FOLD: begin
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (!r_out_valid || o_hdr.ready) begin
                    out_load = 1'b1;
                    if (r_idx == HDR_LAST_IDX) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Descriptor and checksum datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head;
        end
        if (r_state == B_SUM) begin
            r_ip_acc  <= ip_acc;
            r_udp_acc <= udp_acc;
        end
        if (r_state == B_FOLD) begin
            r_ip_sum  <= ~ip_fold;
            r_udp_sum <= udp_csum;
        end
    end

    // Word counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (out_load) begin
            r_idx <= (r_idx == HDR_LAST_IDX) ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output register: holds an item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_hdr.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= word_sel;
            r_out_last <= (r_idx == HDR_LAST_IDX);
        end
    end

    assign o_hdr.valid       = r_out_valid;
    assign o_hdr.header_word = r_out_word;
    assign o_hdr.header_last = r_out_last;

endmodule

FILE: hw/rtl/udp_ipv4_encap_header_gen.sv
// The first header item of a packet is loaded after its descriptor is queued, popped, summed
// and folded. Throughput: one payload item per cycle while the queue is not full; per packet
// the back end pops, sums, folds and emits seven items, and a 4-entry queue absorbs bursts.
// Reset is synchronous and active low; it empties the queue, clears sum, count and
// packet ID, and returns the configuration registers to zero except udp_sum_enable, which becomes 1.
// Top level: configuration registers, front end, descriptor queue and back end.
module udp_ipv4_encap_header_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uig_in_if.sink      i_pkt,
    uig_out_if.source   o_hdr,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import uig_pkg::*;

    t_cfg          r_cfg;
    t_queue_status q_status;
    t_desc         push_desc;
    t_desc         head;
    logic          push;
    logic          pop;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{source_address: 32'h0, source_port: 16'h0, dest_address: 32'h0,
                       dest_port: 16'h0, use_annotation: 1'b0, udp_sum_enable: 1'b1};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_ADDRESS: r_cfg.source_address <= i_cfg_data;
                CFG_SOURCE_PORT:    r_cfg.source_port    <= i_cfg_data[15:0];
                CFG_DEST_ADDRESS:   r_cfg.dest_address   <= i_cfg_data;
                CFG_DEST_PORT:      r_cfg.dest_port      <= i_cfg_data[15:0];
                CFG_USE_ANNOTATION: r_cfg.use_annotation <= i_cfg_data[0];
                CFG_UDP_SUM_ENABLE: r_cfg.udp_sum_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    uig_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pkt            (i_pkt),
        .i_use_annotation (r_cfg.use_annotation),
        .i_dest_address   (r_cfg.dest_address),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_push_desc      (push_desc)
    );

    uig_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    uig_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_hdr      (o_hdr)
    );

endmodule

FILE: test/udp_ipv4_encap_header_gen_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for udp_ipv4_encap_header_gen: payload items go in, header items
// are predicted from a local model of sums, lengths and packet IDs and compared in order.
// Depends on uig_pkg, uig_in_if, uig_out_if and the block itself.
module udp_ipv4_encap_header_gen_test;
    import uig_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 60;
    localparam int SHOW_MAX       = 10;

    // One payload item, optionally with a header that is known by inspection.
    typedef struct packed {
        logic [31:0]      word;
        logic [2:0]       vb;
        logic             last;
        logic [31:0]      anno;
        logic             has_fixed;
        logic [6:0][31:0] fixed;
    } t_row;

    // One header item as it leaves the block.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_hdr_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    uig_in_if  pkt_if ();
    uig_out_if hdr_if ();

    udp_ipv4_encap_header_gen u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (pkt_if),
        .o_hdr       (hdr_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Local copy of the configuration and of the per-packet state.
    t_cfg        cfg_shadow;
    logic [31:0] pay_sum;
    logic [15:0] pay_len;
    logic [15:0] next_id;

    t_hdr_item header_due_q[$];
    t_row      directed_rows[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        hold_req = 1'b0;
    bit        recv_stall_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fold a wide sum into 16 bits with end-around carry.
    function automatic logic [15:0] ones_fold(input logic [63:0] x);
        while (x[63:16] != 48'h0)
            x = {48'h0, x[15:0]} + {16'h0, x[63:16]};
        return x[15:0];
    endfunction

    // Advance the packet state by one payload item; on the last item, build the header.
    function automatic bit predict_header(input t_row r, output logic [6:0][31:0] hw);
        logic [2:0]  n;
        logic [15:0] room;
        logic [31:0] mask;
        logic [31:0] w;
        logic [31:0] dst;
        logic [63:0] acc;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] udp_ck;
        int          k;
        hw = '0;
        n = (r.vb > 3'd4) ? 3'd4 : r.vb;
        room = (pay_len < MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES - pay_len : 16'd0;
        if ({13'h0, n} > room)
            n = room[2:0];
        mask = (n == 3'd0) ? 32'h0 : (32'hFFFF_FFFF << (8 * (4 - n)));
        w = r.word & mask;
        acc = 64'(pay_sum) + 64'(w[31:16]) + 64'(w[15:0]);
        pay_sum = acc[31:0] + acc[63:32];
        pay_len = pay_len + 16'(n);
        if (!r.last)
            return 1'b0;

        dst = cfg_shadow.use_annotation ? r.anno : cfg_shadow.dest_address;
        ip_len = IP_HDR_BYTES + UDP_HDR_BYTES + pay_len;
        udp_len = UDP_HDR_BYTES + pay_len;
        hw[0] = {HDR_VER_IHL, 8'h00, ip_len};
        hw[1] = {next_id, 16'h0000};
        hw[2] = {HDR_TTL, PROTO_UDP, 16'h0000};
        hw[3] = cfg_shadow.source_address;
        hw[4] = dst;
        acc = 64'h0;
        for (k = 0; k < 5; k++)
            acc = acc + 64'(hw[k][31:16]) + 64'(hw[k][15:0]);
        hw[2][15:0] = ~ones_fold(acc);
        hw[5] = {cfg_shadow.source_port, cfg_shadow.dest_port};

        // Pseudo-header sum; a zero result goes out as all ones.
        udp_ck = 16'h0;
        if (cfg_shadow.udp_sum_enable) begin
            acc = 64'(pay_sum) + 64'(cfg_shadow.source_port) + 64'(cfg_shadow.dest_port)
                + 64'(udp_len) + 64'(cfg_shadow.source_address[31:16])
                + 64'(cfg_shadow.source_address[15:0]) + 64'(dst[31:16])
                + 64'(dst[15:0]) + 64'(PROTO_UDP) + 64'(udp_len);
            udp_ck = ~ones_fold(acc);
            if (udp_ck == 16'h0)
                udp_ck = 16'hFFFF;
        end
        hw[6] = {udp_len, udp_ck};

        pay_sum = 32'h0;
        pay_len = 16'h0;
        next_id = next_id + 16'd1;
        return 1'b1;
    endfunction

    // Present one payload item after a gap and queue the header it completes.
    task automatic offer_payload(input t_row r, input int gap);
        logic [6:0][31:0] hw;
        t_hdr_item        item;
        int               k;
        repeat (gap) begin
            pkt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pkt_if.valid           <= 1'b1;
        pkt_if.payload_word    <= r.word;
        pkt_if.valid_bytes     <= r.vb;
        pkt_if.end_of_payload  <= r.last;
        pkt_if.dest_annotation <= r.anno;
        do @(posedge i_clk); while (!pkt_if.ready);
        if (predict_header(r, hw)) begin
            for (k = 0; k < 7; k++) begin
                item.word = r.has_fixed ? r.fixed[k] : hw[k];
                item.last = (k == 6);
                header_due_q.push_back(item);
            end
        end
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [31:0] word, input logic [2:0] vb, input logic last,
                           input logic [31:0] anno);
        t_row r;
        r = '0;
        r.word = word;
        r.vb = vb;
        r.last = last;
        r.anno = anno;
        directed_rows.push_back(r);
    endtask

    // A packet of random content; short or oversized byte counts now and then.
    task automatic send_random_packet(input int n_words, input bit gaps_on);
        t_row r;
        int   k;
        for (k = 0; k < n_words; k++) begin
            r = '0;
            r.word = $urandom;
            r.anno = $urandom;
            r.last = (k == n_words - 1);
            if (r.last)
                r.vb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(1, 4));
            else
                r.vb = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            offer_payload(r, gaps_on ? $urandom_range(0, 9) : 0);
        end
    endtask

    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 8);
            send_random_packet(len, $urandom_range(0, 3) != 0);
            sent += len;
        end
    endtask

    // Let every header item drain and the back end go quiet.
    task automatic wait_drained();
        while (header_due_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
    endtask

    // Write every register back to back, then lower the enable.
    task automatic load_config(input t_cfg c);
        put_reg(CFG_SOURCE_ADDRESS, c.source_address);
        put_reg(CFG_SOURCE_PORT, {16'h0, c.source_port});
        put_reg(CFG_DEST_ADDRESS, c.dest_address);
        put_reg(CFG_DEST_PORT, {16'h0, c.dest_port});
        put_reg(CFG_USE_ANNOTATION, {31'h0, c.use_annotation});
        put_reg(CFG_UDP_SUM_ENABLE, {31'h0, c.udp_sum_enable});
        cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    // Settings per phase: all ones, random without UDP sum, zero addresses and ports, random.
    function automatic t_cfg pick_config(input int mode);
        t_cfg c;
        c.source_address = $urandom;
        c.source_port    = 16'($urandom);
        c.dest_address   = $urandom;
        c.dest_port      = 16'($urandom);
        c.use_annotation = 1'($urandom);
        c.udp_sum_enable = 1'b1;
        case (mode)
            0: begin
                c.source_address = 32'hFFFF_FFFF;
                c.source_port    = 16'hFFFF;
                c.dest_address   = 32'hFFFF_FFFF;
                c.dest_port      = 16'hFFFF;
                c.use_annotation = 1'b0;
            end
            1: begin
                c.use_annotation = 1'b1;
                c.udp_sum_enable = 1'b0;
            end
            2: begin
                c = '0;
                c.use_annotation = 1'b1;
                c.udp_sum_enable = 1'b1;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // Header receiver: random stalls with quiet stretches, plus one long hold-off.
    initial begin
        int gap;
        int quiet_left;
        quiet_left = 0;
        hdr_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hdr_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (quiet_left == 0 && $urandom_range(0, 4) == 0)
                quiet_left = $urandom_range(7, 30);
            gap = (!recv_stall_on || quiet_left > 0) ? 0 : $urandom_range(0, 9);
            if (quiet_left > 0)
                quiet_left--;
            repeat (gap) begin
                hdr_if.ready <= 1'b0;
                @(negedge i_clk);
            end
            hdr_if.ready <= 1'b1;
            do @(posedge i_clk); while (!hdr_if.valid);
        end
    end

    // Compare each accepted header item with the oldest one due; watch for a hang.
    always @(posedge i_clk) begin : check_headers
        t_hdr_item got;
        t_hdr_item want;
        if (i_rst_n && hdr_if.valid && hdr_if.ready) begin
            got.word = hdr_if.header_word;
            got.last = hdr_if.header_last;
            if (header_due_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("%0t: header item with none due: word %h last %0b",
                             $time, got.word, got.last);
            end else begin
                want = header_due_q.pop_front();
                if (got.word !== want.word || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("%0t: header mismatch: expected %h/%0b, got %h/%0b",
                                 $time, want.word, want.last, got.word, got.last);
                end
            end
        end
        if ((pkt_if.valid && pkt_if.ready) || (hdr_if.valid && hdr_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("udp_ipv4_encap_header_gen_test: done, errors");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        int   k;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SOURCE_ADDRESS;
        cfg_data = 32'h0;
        pkt_if.valid = 1'b0;
        pkt_if.payload_word = 32'h0;
        pkt_if.valid_bytes = 3'd0;
        pkt_if.end_of_payload = 1'b0;
        pkt_if.dest_annotation = 32'h0;
        cfg_shadow = '0;
        cfg_shadow.udp_sum_enable = 1'b1;
        pay_sum = 32'h0;
        pay_len = 16'h0;
        next_id = 16'h0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under the reset configuration.
        add_row(32'hA5A5_A5A5, 3'd0, 1'b1, 32'h0);
        directed_rows[0].has_fixed = 1'b1;
        directed_rows[0].fixed = {32'h0008_FFDE, 32'h0, 32'h0, 32'h0,
                                  32'hFA11_C0D1, 32'h0, 32'h4500_001C};
        add_row(32'hFFFF_FFFF, 3'd4, 1'b1, 32'hFFFF_FFFF);
        add_row(32'h0000_0000, 3'd4, 1'b1, 32'h0);
        add_row(32'h1234_5678, 3'd1, 1'b1, 32'h0);    // odd last byte, padded
        add_row(32'h9ABC_DEF0, 3'd3, 1'b1, 32'hFFFF_FFFF);
        add_row(32'hFFD6_0000, 3'd4, 1'b1, 32'h0);    // UDP sum computes to zero, sent as all ones
        add_row(32'hFFFF_FFFF, 3'd7, 1'b0, 32'h0);    // too many valid bytes
        add_row(32'h1122_3344, 3'd5, 1'b0, 32'h0);
        add_row(32'hCAFE_BABE, 3'd1, 1'b0, 32'h0);    // short word before the end
        add_row(32'h0BAD_F00D, 3'd0, 1'b0, 32'h0);    // no bytes, not the end
        add_row(32'hFFFF_FFFF, 3'd4, 1'b0, 32'h0);
        add_row(32'h8000_0001, 3'd2, 1'b1, 32'hFFFF_FFFF);
        add_row(32'h7FFF_FFFF, 3'd6, 1'b1, 32'h0);
        add_row(32'hFFFF_FFFF, 3'd4, 1'b0, 32'h0);
        add_row(32'hFFFF_FFFF, 3'd4, 1'b0, 32'h0);
        add_row(32'hFFFF_FFFF, 3'd4, 1'b1, 32'hFFFF_FFFF);
        add_row(32'h0000_0001, 3'd4, 1'b1, 32'h0);
        foreach (directed_rows[k])
            offer_payload(directed_rows[k], $urandom_range(0, 9));
        pkt_if.valid <= 1'b0;

        // Random phases, each under new settings; the first one starts with a long hold-off.
        for (k = 0; k < 4; k++) begin
            wait_drained();
            load_config(pick_config(k));
            if (k == 0)
                hold_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
            pkt_if.valid <= 1'b0;
        end

        // A few packets at full rate with the receiver always ready.
        recv_stall_on = 1'b0;
        send_random_packet(3, 1'b0);
        repeat (8) send_random_packet(1, 1'b0);
        pkt_if.valid <= 1'b0;

        wait_drained();
        if (mismatch_count == 0 && header_due_q.size() == 0)
            $display("udp_ipv4_encap_header_gen_test: done, clean");
        else
            $display("udp_ipv4_encap_header_gen_test: done, errors");
        $finish;
    end

endmodule
